// File: rtl/jmsd_pkg.sv
// ----------------------------------------------------------------------------
// jmsd_pkg
// Shared types, sizes and register indexes of the joint motion settle detector.
// ----------------------------------------------------------------------------
package jmsd_pkg;

   localparam int JOINT_COUNT   = 7;
   localparam int HISTORY_DEPTH = 10;
   localparam int POS_W         = 16;
   localparam int TOL_W         = 16;
   localparam int CSR_DATA_W    = 16;
   localparam int HEAD_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CSR_INDEX_W   = $clog2(JOINT_COUNT + 1);

   // register indexes: tolerance first, then one commanded position per joint
   localparam logic [CSR_INDEX_W-1:0] CSR_TOLERANCE = CSR_INDEX_W'(0);
   localparam int                     CSR_CMD_BASE  = 1;

   typedef logic signed [POS_W-1:0]       pos_type;
   typedef pos_type [JOINT_COUNT-1:0]     row_type;
   typedef row_type [HISTORY_DEPTH-1:0]   hist_type;
   typedef logic [TOL_W-1:0]              tol_type;

   typedef struct packed {
      logic signed [15:0] joint_pos_0;
      logic signed [15:0] joint_pos_1;
      logic signed [15:0] joint_pos_2;
      logic signed [15:0] joint_pos_3;
      logic signed [15:0] joint_pos_4;
      logic signed [15:0] joint_pos_5;
      logic signed [15:0] joint_pos_6;
   } req_payload_type;

   typedef struct packed {
      logic target_reached;
      logic motion_started;
      logic still_moving;
   } rsp_payload_type;

   function automatic row_type payload_to_row(input req_payload_type p);
      row_type r;
      r[0] = p.joint_pos_0;
      r[1] = p.joint_pos_1;
      r[2] = p.joint_pos_2;
      r[3] = p.joint_pos_3;
      r[4] = p.joint_pos_4;
      r[5] = p.joint_pos_5;
      r[6] = p.joint_pos_6;
      return r;
   endfunction

endpackage

// File: rtl/joint_motion_settle_detector_unit.sv
// ----------------------------------------------------------------------------
// joint_motion_settle_detector_unit
// Decides per joint sample whether the arm reached its commanded pose.
// ----------------------------------------------------------------------------
// One transfer carries seven joint positions (signed Q3.12 rad) and yields
// one result transfer: an input register, then one compute stage that compares
// the sample against the commanded pose and against all ten history rows in
// parallel, then a result register. A new sample is taken every cycle unless
// the result channel stalls; the rate is set by that compute stage, which also
// writes the history ring, so each sample sees the ring left by the one before
// it. The first sample after reset fills the whole ring. A result counts as
// reached when every joint is within tolerance of its command, or when motion
// had been seen and has now stopped. Writing any commanded register clears the
// motion-seen flag; write registers only while the block is idle.
// ----------------------------------------------------------------------------
module joint_motion_settle_detector_unit
   import jmsd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // sample channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_payload_type        req_payload,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_payload_type        rsp_payload,
   // register write port
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // registers
   tol_type         tolerance_ff;
   row_type         commanded_ff;
   logic            movement_seen_ff;
   logic            movement_seen_in;
   logic            s1_valid_ff;
   row_type         s1_row_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;
   rsp_payload_type rsp_payload_in;

   logic                     advance;
   logic                     step;
   logic                     at_command;
   logic [HISTORY_DEPTH-1:0] hist_dev;
   logic                     moving_raw;
   logic                     cmd_dev;
   logic                     cmd_write;
   hist_type                 view;

   // Advance the compute stage whenever the result register is free or drained.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step      = s1_valid_ff && advance;
   assign req_ready = !s1_valid_ff || advance;

   // ---- configuration --------------------------------------------------------
   always_comb begin
      cmd_write = 1'b0;
      for (int j = 0; j < JOINT_COUNT; j++) begin
         if (csr_we && csr_index == CSR_INDEX_W'(CSR_CMD_BASE + j)) begin
            cmd_write = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= TOL_W'(41);
         commanded_ff <= '0;
      end else begin
         if (csr_we && csr_index == CSR_TOLERANCE) begin
            tolerance_ff <= csr_wdata[TOL_W-1:0];
         end
         for (int j = 0; j < JOINT_COUNT; j++) begin
            if (csr_we && csr_index == CSR_INDEX_W'(CSR_CMD_BASE + j)) begin
               commanded_ff[j] <= csr_wdata[POS_W-1:0];
            end
         end
      end
   end

   // ---- input register -------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_row_ff <= payload_to_row(req_payload);
      end
   end

   // ---- compute stage --------------------------------------------------------
   jmsd_history u_history (
      .clock  (clock),
      .reset  (reset),
      .update (step),
      .sample (s1_row_ff),
      .view   (view)
   );

   jmsd_row_cmp u_cmd_cmp (
      .row_a     (s1_row_ff),
      .row_b     (commanded_ff),
      .tolerance (tolerance_ff),
      .deviate   (cmd_dev)
   );

   for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_hist_cmp
      jmsd_row_cmp u_hist_cmp (
         .row_a     (view[i]),
         .row_b     (s1_row_ff),
         .tolerance (tolerance_ff),
         .deviate   (hist_dev[i])
      );
   end

   assign at_command = !cmd_dev;
   assign moving_raw = |hist_dev;

   always_comb begin
      // motion only counts when the pose is off command
      movement_seen_in              = movement_seen_ff || (!at_command && moving_raw);
      rsp_payload_in.still_moving   = !at_command && moving_raw;
      rsp_payload_in.motion_started = movement_seen_in;
      rsp_payload_in.target_reached = at_command || (movement_seen_ff && !moving_raw);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         movement_seen_ff <= 1'b0;
      end else if (step) begin
         movement_seen_ff <= movement_seen_in;
      end else if (cmd_write) begin
         // a new command restarts the motion tracking
         movement_seen_ff <= 1'b0;
      end
   end

   // ---- result register ------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// File: rtl/jmsd_row_cmp.sv
// ----------------------------------------------------------------------------
// jmsd_row_cmp
// Flags two joint rows that differ by more than tolerance on any joint.
// ----------------------------------------------------------------------------
module jmsd_row_cmp
   import jmsd_pkg::*;
(
   input  row_type row_a,
   input  row_type row_b,
   input  tol_type tolerance,
   output logic    deviate
);

   logic signed [POS_W:0] diff [JOINT_COUNT];
   logic        [POS_W:0] mag  [JOINT_COUNT];
   logic [JOINT_COUNT-1:0] over;

   always_comb begin
      for (int j = 0; j < JOINT_COUNT; j++) begin
         // exact 17-bit difference, then magnitude
         diff[j] = {row_a[j][POS_W-1], row_a[j]} - {row_b[j][POS_W-1], row_b[j]};
         mag[j]  = diff[j][POS_W] ? (POS_W+1)'(-diff[j]) : (POS_W+1)'(diff[j]);
         over[j] = mag[j] > {1'b0, tolerance};
      end
   end

   assign deviate = |over;

endmodule

// File: rtl/jmsd_history.sv
// ----------------------------------------------------------------------------
// jmsd_history
// History ring of past joint rows plus the latest row.
// ----------------------------------------------------------------------------
module jmsd_history
   import jmsd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     update,
   input  row_type  sample,
   output hist_type view
);

   hist_type            hist_ff;
   row_type             current_ff;
   logic [HEAD_W-1:0]   head_ff;
   logic [HEAD_W-1:0]   head_in;
   logic                first_ff;

   // ring as it stands once this sample is taken in
   always_comb begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         if (first_ff) begin
            view[i] = sample;
         end else if (head_ff == HEAD_W'(i)) begin
            view[i] = current_ff;
         end else begin
            view[i] = hist_ff[i];
         end
      end
   end

   always_comb begin
      if (first_ff || head_ff == HEAD_W'(HISTORY_DEPTH - 1)) begin
         head_in = '0;
      end else begin
         head_in = head_ff + HEAD_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
         head_ff  <= '0;
      end else if (update) begin
         first_ff <= 1'b0;
         head_ff  <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         hist_ff    <= view;
         current_ff <= sample;
      end
   end

endmodule
